// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue with class counts.
// Holds sizes, status and request codes, and the entry, request and result types.
// No dependencies.
`default_nettype none

package spq_pkg;

  // Queue size and the index widths that follow from it.
  localparam int QUEUE_DEPTH = 64;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = 7;

  // Field widths of the stream payloads.
  localparam int VALUE_W = 32;
  localparam int CLASS_W = 2;
  localparam int TAG_W   = 32;
  localparam int NUM_CLASSES = 3;

  // Request kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Class codes.
  localparam logic [CLASS_W-1:0] CLASS_PENDING  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_PAID     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_ARCHIVED = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [CLASS_W-1:0] cls;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // One request into the queue engine.
  typedef struct packed {
    logic   kind;
    entry_t entry;
  } req_t;

  // One result out of the queue engine.
  typedef struct packed {
    status_t          status;
    entry_t           popped;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] paid_count;
    logic [CNT_W-1:0] archived_count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_engine.sv =====
// Queue engine: sorted entry memory, fill level, class counters and the sequencer.
// Depends on spq_pkg.
`default_nettype none

module spq_engine
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      req_ready,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_POP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Entry memory, kept in ascending value order from address zero.
  entry_t store_mem [QUEUE_DEPTH];

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  entry_t              new_r, new_nxt;
  entry_t              pop_r, pop_nxt;
  status_t             status_r, status_nxt;
  logic [CNT_W-1:0]    cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0]    cnt_nxt [NUM_CLASSES];
  entry_t              rd_data_r;

  logic                we;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [FILL_W-1:0]   fill_dec;
  logic [ADDR_W-1:0]   idx_m1;
  logic                place;

  assign fill_dec = fill_r - FILL_W'(1);
  assign idx_m1   = idx_r - ADDR_W'(1);
  // The new entry goes at idx once the entry below it is strictly smaller.
  assign place    = (idx_r == '0) ||
                    ($signed(new_r.value) > $signed(rd_data_r.value));

  // Sequencer: inserts walk down from the top, moving each larger or equal entry up.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    pop_nxt    = pop_r;
    status_nxt = status_r;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    we      = 1'b0;
    wr_addr = idx_r;
    wr_data = new_r;
    rd_addr = fill_dec[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          new_nxt    = req.entry;
          pop_nxt    = '0;
          status_nxt = STATUS_DONE;
          if (req.kind == KIND_POP) begin
            if (fill_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_POP;
            end
          end else begin
            if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_DONE;
            end else begin
              idx_nxt   = fill_r[ADDR_W-1:0];
              state_nxt = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        if (place) begin
          wr_data  = new_r;
          fill_nxt = fill_r + FILL_W'(1);
          for (int k = 0; k < NUM_CLASSES; k++) begin
            if (new_r.cls == CLASS_W'(k)) begin
              cnt_nxt[k] = cnt_r[k] + CNT_W'(1);
            end
          end
          state_nxt = S_DONE;
        end else begin
          wr_data = rd_data_r;
          idx_nxt = idx_m1;
          rd_addr = idx_m1 - ADDR_W'(1);
        end
      end
      S_POP: begin
        pop_nxt  = rd_data_r;
        fill_nxt = fill_dec;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (rd_data_r.cls == CLASS_W'(k)) begin
            cnt_nxt[k] = cnt_r[k] - CNT_W'(1);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    new_r    <= new_nxt;
    pop_r    <= pop_nxt;
    status_r <= status_nxt;
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  assign req_ready          = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.popped         = pop_r;
  assign res.pending_count  = cnt_r[0];
  assign res.paid_count     = cnt_r[1];
  assign res.archived_count = cnt_r[2];

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_with_class_counts_unit.sv =====
// Top level of the sorted priority queue: stream ports and the result register.
// Depends on spq_pkg and spq_engine.
//
//   Channel | Direction | tdata fields (low bit first)                  | tuser
//   in_     | request   | entry_value, entry_class, entry_tag, pad      | kind
//   out_    | result    | popped_value, popped_class, popped_tag,       | status
//           |           | pending, paid, archived counts, pad           |
//
// A pop passes from acceptance through S_POP to S_DONE, from which the result register is loaded.
// An insert passes through S_SHIFT, staying there for every stored entry that is
// equal to or larger than the new value, since the single write port moves one
// entry per cycle. Reset clears the fill level and the class counters; memory
// contents are not cleared. A new request is accepted while a result waits in
// the output register, and the engine holds its next result until that is taken.
`default_nettype none

module sorted_priority_queue_with_class_counts_unit
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // entry_value[31:0], entry_class[33:32], entry_tag[65:34]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // popped_value[31:0], popped_class[33:32],
                                       // popped_tag[65:34], pending_count[72:66],
                                       // paid_count[79:73], archived_count[86:80]
  output logic [1:0]       out_tuser   // status
);

  req_t  req;
  logic  req_ready;
  logic  res_valid;
  res_t  res;
  logic  res_ready;

  logic        out_valid_r, out_valid_nxt;
  logic [87:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  // Unpack the request.
  assign req.kind         = in_tuser;
  assign req.entry.value  = in_tdata[31:0];
  assign req.entry.cls    = in_tdata[33:32];
  assign req.entry.tag    = in_tdata[65:34];

  spq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_tready = req_ready;
  assign res_ready = !out_valid_r || out_tready;

  // Output register: load a result when the slot is free or being emptied.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, res.archived_count, res.paid_count, res.pending_count,
                       res.popped.tag, res.popped.cls, res.popped.value};
      out_user_nxt  = res.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checks for the sorted priority queue top level, with its bind.
// Depends on spq_pkg and sorted_priority_queue_with_class_counts_unit.
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  logic [8:0] count_sum;

  assign count_sum = 9'(out_tdata[72:66]) + 9'(out_tdata[79:73]) + 9'(out_tdata[86:80]);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only the three status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STATUS_DONE) || (out_tuser == STATUS_EMPTY) ||
                   (out_tuser == STATUS_FULL))
    else $error("unknown status code");

  // The class counts never add up to more than the queue holds.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count_sum <= 9'(QUEUE_DEPTH))
    else $error("class counts exceed queue depth");

  // An empty pop or a dropped insert returns no entry.
  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STATUS_DONE) |-> out_tdata[65:0] == '0)
    else $error("entry fields set on a failed request");

  // No result appears in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_priority_queue_with_class_counts_unit spq_checker u_spq_checker (.*);

`default_nettype wire
